FILE: rtl/rsb_pkg.sv
`timescale 1ns / 1ps

package rsb_pkg;

  // Recolor modes; undefined codes fall back to brighten
  typedef enum logic [2:0] {
    ModeBright  = 3'd0,
    ModeRecolor = 3'd1,
    ModeSwap    = 3'd2,
    ModeGhost   = 3'd3,
    ModeGlow    = 3'd4
  } mode_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgLeftX      = 3'd0,
    CfgTopY       = 3'd1,
    CfgWidth      = 3'd2,
    CfgHeight     = 3'd3,
    CfgDrawMode   = 3'd4,
    CfgBrightness = 3'd5,
    CfgTargetHue  = 3'd6,
    CfgMatchHue   = 3'd7
  } cfg_reg_e;

  localparam int unsigned CfgDataW = 11;
  localparam int unsigned PosW     = 12;
  localparam logic [7:0]  TagSkip  = 8'h80;

  typedef struct packed {
    mode_e             draw_mode;
    logic signed [5:0] brightness;
    logic [2:0]        target_hue;
    logic [2:0]        match_hue;
  } shade_cfg_t;

  // Keep the hue, add d to the low five bits and clamp to 0..31
  function automatic logic [7:0] light(input logic [7:0] c, input logic signed [7:0] d);
    logic signed [7:0] v;
    logic [4:0]        lo;
    v = $signed({3'b000, c[4:0]}) + d;
    if (v < 0) begin
      lo = 5'd0;
    end else if (v > 8'sd31) begin
      lo = 5'd31;
    end else begin
      lo = v[4:0];
    end
    return {c[7:5], lo};
  endfunction

endpackage

FILE: rtl/rsb_shade.sv
`timescale 1ns / 1ps

module rsb_shade import rsb_pkg::*; (
  input  logic [7:0] src_i,
  input  logic [7:0] bg_i,
  input  shade_cfg_t cfg_i,
  output logic [7:0] value_o
);

  logic [7:0]        recolored;
  logic signed [7:0] bright_ext;
  logic signed [7:0] glow_ofs;

  assign recolored  = {cfg_i.target_hue, src_i[4:0]};
  assign bright_ext = {{2{cfg_i.brightness[5]}}, cfg_i.brightness};
  assign glow_ofs   = $signed({3'b000, bg_i[4:0]}) + bright_ext;

  always_comb begin
    case (cfg_i.draw_mode)
      ModeRecolor: value_o = light(recolored, bright_ext);
      ModeSwap: begin
        if (src_i[7:5] == cfg_i.match_hue) begin
          value_o = light(recolored, bright_ext);
        end else begin
          value_o = light(src_i, bright_ext);
        end
      end
      ModeGhost: begin
        // hue zero pixels blend: their low bits brighten the background
        if (src_i[7:5] == 3'd0) begin
          value_o = light(bg_i, $signed({3'b000, src_i[4:0]}));
        end else begin
          value_o = light(src_i, bright_ext);
        end
      end
      ModeGlow: value_o = light(src_i, glow_ofs);
      default:  value_o = light(src_i, bright_ext);
    endcase
  end

endmodule

FILE: rtl/rle_sprite_blitter_core.sv
`timescale 1ns / 1ps
// Transparency-RLE sprite blitter: one stream byte in, at most one pixel write out.
// Path: an accepted data byte is held in the input register, then its pixel
// in the result register.
// Throughput: one byte per cycle while the output is not stalled, set by the position/run update loop.
// Reset (async, active low): no sprite active, run and position cleared,
// all configuration registers zero, both pipeline stages empty.

module rle_sprite_blitter_core import rsb_pkg::*; #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          code_byte_i,
  input  logic [7:0]          background_pixel_i,
  input  logic                sprite_start_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [9:0]          pixel_x_o,
  output logic [9:0]          pixel_y_o,
  output logic [7:0]          pixel_value_o
);

  // Screen limits in the signed width used for position math
  localparam logic signed [13:0] ScrW    = 14'(SCREEN_WIDTH);
  localparam logic signed [13:0] ScrH    = 14'(SCREEN_HEIGHT);
  localparam logic signed [13:0] LastRow = 14'(SCREEN_HEIGHT - 1);
  localparam logic signed [11:0] StartMaxX = 12'(SCREEN_WIDTH - 1);
  localparam logic signed [11:0] StartMaxY = 12'(SCREEN_HEIGHT - 1);

  // Configuration registers
  logic signed [10:0] left_x_q, top_y_q;
  logic [9:0]         width_q, height_q;
  shade_cfg_t         shade_cfg_q;

  // Input stage
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_code_q, s1_bg_q;
  logic       s1_start_q;

  // Sprite walk state
  logic            run_q, run_d;
  logic [6:0]      rem_q, rem_d;
  logic [PosW-1:0] col_q, col_d;
  logic [PosW-1:0] row_q, row_d;
  logic            fin_q, fin_d;

  // Result stage
  logic       out_valid_q, out_valid_d;
  logic [9:0] px_q, py_q;
  logic [7:0] pv_q;

  logic       out_free;
  logic       step;
  logic       in_accept;

  // Working values after a sprite start has been applied
  logic            eff_run, eff_fin, start_fin;
  logic [6:0]      eff_rem;
  logic [PosW-1:0] eff_col, eff_row, col_n, row_inc;
  logic            row_chk;
  logic            res_valid;
  logic signed [13:0] x_pos, y_pos, y_inc;
  logic signed [11:0] lx_ext, ty_ext;
  logic [7:0]      shade_val;

  assign cfg_ready_o = 1'b1;

  // The result register frees up when empty or being drained this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_x_q    <= '0;
      top_y_q     <= '0;
      width_q     <= '0;
      height_q    <= '0;
      shade_cfg_q <= '{draw_mode: ModeBright, brightness: '0, target_hue: '0,
                       match_hue: '0};
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgLeftX:      left_x_q <= cfg_data_i;
        CfgTopY:       top_y_q <= cfg_data_i;
        CfgWidth:      width_q <= cfg_data_i[9:0];
        CfgHeight:     height_q <= cfg_data_i[9:0];
        CfgDrawMode:   shade_cfg_q.draw_mode <= mode_e'(cfg_data_i[2:0]);
        CfgBrightness: shade_cfg_q.brightness <= cfg_data_i[5:0];
        CfgTargetHue:  shade_cfg_q.target_hue <= cfg_data_i[2:0];
        CfgMatchHue:   shade_cfg_q.match_hue <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Input register: load when empty or when the held item advances
  assign s1_valid_d = in_accept ? 1'b1 : (step ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_code_q  <= code_byte_i;
      s1_bg_q    <= background_pixel_i;
      s1_start_q <= sprite_start_i;
    end
  end

  assign lx_ext = {left_x_q[10], left_x_q};
  assign ty_ext = {top_y_q[10], top_y_q};
  // A sprite that starts right of or below the screen, or has no rows, is done at once
  assign start_fin = (lx_ext > StartMaxX) || (ty_ext > StartMaxY) || (height_q == 10'd0);

  assign eff_run = s1_start_q ? 1'b0 : run_q;
  assign eff_rem = s1_start_q ? 7'd0 : rem_q;
  assign eff_col = s1_start_q ? '0 : col_q;
  assign eff_row = s1_start_q ? '0 : row_q;
  assign eff_fin = s1_start_q ? start_fin : fin_q;

  assign x_pos   = {{3{left_x_q[10]}}, left_x_q} + {2'b00, eff_col};
  assign y_pos   = {{3{top_y_q[10]}}, top_y_q} + {2'b00, eff_row};
  assign row_inc = eff_row + 12'd1;
  assign y_inc   = {{3{top_y_q[10]}}, top_y_q} + {2'b00, row_inc};

  always_comb begin
    run_d     = eff_run;
    rem_d     = eff_rem;
    col_n     = eff_col;
    row_d     = eff_row;
    fin_d     = eff_fin;
    row_chk   = 1'b0;
    res_valid = 1'b0;
    if (!eff_fin) begin
      if (eff_run) begin
        // Data byte: write only when inside the screen window
        res_valid = !x_pos[13] && (x_pos < ScrW) && !y_pos[13] && (y_pos < ScrH);
        col_n     = eff_col + 12'd1;
        rem_d     = eff_rem - 7'd1;
        if (rem_d == 7'd0) begin
          run_d   = 1'b0;
          row_chk = 1'b1;
        end
      end else if ((s1_code_q & TagSkip) != 8'd0) begin
        // Skip tag: advance over transparent pixels
        col_n   = eff_col + {5'b00000, s1_code_q[6:0]};
        row_chk = 1'b1;
      end else if (s1_code_q == 8'd0) begin
        row_chk = 1'b1;
      end else begin
        run_d = 1'b1;
        rem_d = s1_code_q[6:0];
      end
    end
    col_d = col_n;
    // Row wrap: start the next row and end the sprite past its last row or the screen
    if (row_chk && (col_n >= {2'b00, width_q})) begin
      col_d = '0;
      row_d = row_inc;
      if ((y_inc > LastRow) || (row_inc >= {2'b00, height_q})) begin
        fin_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      rem_q <= '0;
      col_q <= '0;
      row_q <= '0;
      fin_q <= 1'b1;
    end else if (step) begin
      run_q <= run_d;
      rem_q <= rem_d;
      col_q <= col_d;
      row_q <= row_d;
      fin_q <= fin_d;
    end
  end

  rsb_shade u_shade (
    .src_i   (s1_code_q),
    .bg_i    (s1_bg_q),
    .cfg_i   (shade_cfg_q),
    .value_o (shade_val)
  );

  // Result register: refill whenever it is free, drop bytes that write nothing
  assign out_valid_d = out_free ? (s1_valid_q && res_valid) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      px_q <= x_pos[9:0];
      py_q <= y_pos[9:0];
      pv_q <= shade_val;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_value_o = pv_q;

`ifndef ASSERT_OFF
  // Every write lands inside the screen window
  a_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (32'(pixel_x_o) < SCREEN_WIDTH) && (32'(pixel_y_o) < SCREEN_HEIGHT))
    else $error("pixel write outside the screen window");

  // An open data run always has bytes left
  a_run_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (rem_q != 7'd0))
    else $error("data run open with zero bytes remaining");

  // A finished sprite emits nothing until the next start
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && fin_q && !s1_start_q) |=> !out_valid_q)
    else $error("pixel written after sprite finished");
`endif

endmodule

FILE: tb/tb_rle_sprite_blitter_core.sv
`timescale 1ns / 1ps

module tb_rle_sprite_blitter_core import rsb_pkg::*; ();

  localparam int ScrW        = 640;
  localparam int ScrH        = 480;
  localparam int BusyPct     = 34;
  localparam int DrainCycles = 6;      // drain margin after the last expected pixel
  localparam int RandomBytes = 450;
  localparam int MaxReports  = 10;
  localparam int CycleLimit  = 400000;

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    logic [7:0] value;
  } pixel_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_valid   = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index   = '0;
  logic [CfgDataW-1:0] cfg_data    = '0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [7:0]          code_byte   = '0;
  logic [7:0]          bg_pixel    = '0;
  logic                sprite_start = 1'b0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [9:0]          pixel_x;
  logic [9:0]          pixel_y;
  logic [7:0]          pixel_value;

  rle_sprite_blitter_core #(
    .SCREEN_WIDTH (ScrW),
    .SCREEN_HEIGHT(ScrH)
  ) dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .code_byte_i       (code_byte),
    .background_pixel_i(bg_pixel),
    .sprite_start_i    (sprite_start),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .pixel_x_o         (pixel_x),
    .pixel_y_o         (pixel_y),
    .pixel_value_o     (pixel_value)
  );

  always #4 clk = ~clk;

  // Shadow copy of the register file
  int         r_left_x   = 0;
  int         r_top_y    = 0;
  logic [9:0] r_width    = '0;
  logic [9:0] r_height   = '0;
  logic [2:0] r_mode     = '0;
  int         r_bright   = 0;
  logic [2:0] r_tgt_hue  = '0;
  logic [2:0] r_match_hue = '0;

  // Stream decoder state, mirrored from the block
  logic        run_active  = 1'b0;
  logic [6:0]  run_left    = '0;
  logic [11:0] col_pos     = '0;
  logic [11:0] row_pos     = '0;
  logic        sprite_done = 1'b1;

  pixel_t pending_pixels[$];
  int     mismatch_count = 0;
  int     live_bytes     = 0;   // bytes that reached an active sprite
  int     cycle_count    = 0;
  int     send_idle_pct  = BusyPct;
  int     stall_pct      = BusyPct;
  int     hold_req       = 0;
  int     hold_left      = 0;
  bit     start_next     = 1'b0;

  // ---------------------------------------------------------------------------
  // Pixel prediction
  // ---------------------------------------------------------------------------

  // Keep the hue and clamp the brightness field to 0..31 after adding d
  function automatic logic [7:0] sat_level(input logic [7:0] c, input int d);
    int v;
    v = int'(c[4:0]) + d;
    if (v < 0) v = 0;
    if (v > 31) v = 31;
    return {c[7:5], 5'(v)};
  endfunction

  function automatic logic [7:0] recolor(input logic [7:0] src, input logic [7:0] bg);
    logic [7:0] rec;
    rec = {r_tgt_hue, src[4:0]};
    case (r_mode)
      ModeRecolor: return sat_level(rec, r_bright);
      ModeSwap:    return sat_level((src[7:5] == r_match_hue) ? rec : src, r_bright);
      ModeGhost:   return (src[7:5] == 3'd0) ? sat_level(bg, int'(src))
                                             : sat_level(src, r_bright);
      ModeGlow:    return sat_level(src, int'(bg[4:0]) + r_bright);
      default:     return sat_level(src, r_bright);  // unassigned codes brighten
    endcase
  endfunction

  // Wrap to the next row once the column reaches the sprite width; end the sprite past its last row or the screen
  function automatic void close_row();
    if (col_pos >= 12'(r_width)) begin
      col_pos = '0;
      row_pos = row_pos + 12'd1;
      if (r_top_y + int'(row_pos) > ScrH - 1 || row_pos >= 12'(r_height))
        sprite_done = 1'b1;
    end
  endfunction

  // Advance the decoder by one byte; return 1 when the byte draws a pixel
  function automatic bit predict_pixel(input logic [7:0] code, input logic [7:0] bg,
                                       input bit start, output pixel_t p);
    int  px;
    int  py;
    bit  hit;
    hit = 1'b0;
    p   = '0;
    if (start) begin
      run_active  = 1'b0;
      run_left    = '0;
      col_pos     = '0;
      row_pos     = '0;
      sprite_done = (r_left_x > ScrW - 1) || (r_top_y > ScrH - 1) || (r_height == '0);
    end
    if (sprite_done) return 1'b0;
    live_bytes++;
    if (run_active) begin
      px = r_left_x + int'(col_pos);
      py = r_top_y + int'(row_pos);
      if (px >= 0 && px < ScrW && py >= 0 && py < ScrH) begin
        p.x     = 10'(px);
        p.y     = 10'(py);
        p.value = recolor(code, bg);
        hit     = 1'b1;
      end
      col_pos  = col_pos + 12'd1;
      run_left = run_left - 7'd1;
      if (run_left == '0) begin
        run_active = 1'b0;
        close_row();
      end
    end else if (code[7]) begin
      col_pos = col_pos + 12'(code[6:0]);
      close_row();
    end else if (code == 8'h00) begin
      close_row();
    end else begin
      run_active = 1'b1;
      run_left   = code[6:0];
    end
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Present one stream byte at the falling edge, hold it until accepted;
  // idle at random first
  task automatic send_byte(input logic [7:0] code, input logic [7:0] bg, input bit start);
    pixel_t p;
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    code_byte    <= code;
    bg_pixel     <= bg;
    sprite_start <= start;
    do @(posedge clk); while (in_stall);
    if (predict_pixel(code, bg, start, p)) pending_pixels.push_back(p);
  endtask

  // Send a byte with a random background; the first byte of a sprite carries start
  task automatic put(input logic [7:0] code);
    send_byte(code, 8'($urandom_range(255)), start_next);
    start_next = 1'b0;
  endtask

  // Drop valid and wait until every predicted pixel has come out
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CfgLeftX:      r_left_x    = int'($signed(data));
      CfgTopY:       r_top_y     = int'($signed(data));
      CfgWidth:      r_width     = data[9:0];
      CfgHeight:     r_height    = data[9:0];
      CfgDrawMode:   r_mode      = data[2:0];
      CfgBrightness: r_bright    = int'($signed(data[5:0]));
      CfgTargetHue:  r_tgt_hue   = data[2:0];
      CfgMatchHue:   r_match_hue = data[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_window(input int lx, input int ty, input int w, input int h);
    write_reg(CfgLeftX, 11'(lx));
    write_reg(CfgTopY, 11'(ty));
    write_reg(CfgWidth, 11'(w));
    write_reg(CfgHeight, 11'(h));
  endtask

  // Emit well-formed rows of skip tags and data runs; in wild mode also
  // rewrite registers between rows and abandon the sprite inside a run.
  task automatic draw_rows(input int rows, input bit wild);
    int col;
    int n;
    int k;
    int pick;
    int skip_max;
    int run_max;
    skip_max = (r_width > 10'd64) ? 127 : 8;
    run_max  = (r_width > 10'd64) ? 40 : 8;
    for (int r = 0; r < rows; r++) begin
      col = 0;
      if (wild && $urandom_range(99) < 4) begin
        wait_idle();
        write_reg(CfgDrawMode, 11'($urandom_range(7)));
        write_reg(CfgBrightness, 11'(int'($urandom_range(63)) - 32));
      end
      do begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          put(pick[0] ? TagSkip : 8'h00);  // empty skip or empty data run
        end else if (pick < 35) begin
          k = $urandom_range(skip_max, 1);
          put(TagSkip | 8'(k));
          col += k;
        end else begin
          n = (pick < 38) ? $urandom_range(127, 1) : $urandom_range(run_max, 1);
          put(8'(n));
          for (int i = 0; i < n; i++) begin
            if (wild && $urandom_range(999) < 3) return;
            put(8'($urandom_range(255)));
          end
          col += n;
        end
      end while (col < int'(r_width));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------

  // Stall at random; a requested hold-off overrides it for its whole length
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_pixels
    pixel_t want;
    pixel_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{x: pixel_x, y: pixel_y, value: pixel_value};
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("unexpected pixel: x=%0d y=%0d value=%02h", got.x, got.y, got.value);
      end else begin
        want = pending_pixels.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.value !== want.value) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("pixel mismatch: expected x=%0d y=%0d value=%02h, got x=%0d y=%0d value=%02h",
                     want.x, want.y, want.value, got.x, got.y, got.value);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // No sprite is active after reset: bytes without start draw nothing
  task automatic test_idle_bytes();
    send_byte(8'h05, 8'h00, 1'b0);
    send_byte(8'hFF, 8'hFF, 1'b0);
    wait_idle();
  endtask

  // One short run per mode, alternating between the brightness extremes; the last pass uses
  // an unassigned mode code, which falls back to brighten
  task automatic test_modes();
    set_window(0, 0, 1023, 1023);
    write_reg(CfgTargetHue, 11'd7);
    write_reg(CfgMatchHue, 11'd0);
    for (int m = 0; m < 6; m++) begin
      wait_idle();
      write_reg(CfgDrawMode, 11'(m));
      write_reg(CfgBrightness, (m % 2 != 0) ? 11'(31) : 11'(-32));
      start_next = 1'b1;
      put(8'h02);
      send_byte(8'h1F, 8'h00, 1'b0);
      send_byte(8'hE0, 8'hFF, 1'b0);
    end
    wait_idle();
  endtask

  // Empty tags, the longest skip, a run past the width that starts one column
  // left of the screen, and the sprite leaving the bottom of the screen
  task automatic test_tags();
    set_window(-1, ScrH - 2, 3, 1023);
    write_reg(CfgDrawMode, 11'(ModeBright));
    write_reg(CfgBrightness, 11'd0);
    start_next = 1'b1;
    put(TagSkip);
    put(8'h00);
    put(8'hFF);
    put(8'h05);
    put(8'h00);
    put(8'hFF);
    put(8'h7F);
    put(8'h80);
    put(8'h55);
    put(8'h01);   // sprite already finished: ignored
    wait_idle();
  endtask

  // Starts that finish at once: right of the screen, below it, zero height
  task automatic test_rejected_starts();
    set_window(ScrW, 0, 8, 8);
    start_next = 1'b1;
    put(8'h01);
    put(8'h00);
    wait_idle();
    set_window(0, ScrH, 8, 8);
    start_next = 1'b1;
    put(8'h01);
    wait_idle();
    set_window(0, -1024, 8, 0);
    start_next = 1'b1;
    put(8'h01);
    wait_idle();
  endtask

  // Hold the output off long enough to back the block up into its input,
  // and pause the stream mid-sprite until all pixels have drained
  task automatic test_backpressure();
    set_window(0, 0, 16, 8);
    write_reg(CfgDrawMode, 11'(ModeGlow));
    write_reg(CfgBrightness, 11'd5);
    hold_req   = 300;
    start_next = 1'b1;
    for (int r = 0; r < 8; r++) begin
      if (r == 4) wait_idle();
      put(8'd16);
      repeat (16) put(8'($urandom_range(255)));
    end
    wait_idle();
  endtask

  // Back-to-back bytes with the output always ready
  task automatic test_no_gaps();
    send_idle_pct = 0;
    stall_pct     = 0;
    set_window(5, 10, 20, 6);
    write_reg(CfgDrawMode, 11'(ModeSwap));
    write_reg(CfgMatchHue, 11'($urandom_range(7)));
    start_next = 1'b1;
    draw_rows(6, 1'b0);
    wait_idle();
    send_idle_pct = BusyPct;
    stall_pct     = BusyPct;
  endtask

  task automatic randomize_regs();
    int lx;
    int ty;
    int w;
    int h;
    case ($urandom_range(9))
      0:       lx = -1024;
      1:       lx = 1023;
      2:       lx = ScrW - 1;
      3:       lx = -int'($urandom_range(30, 1));
      default: lx = int'($urandom_range(ScrW - 10));
    endcase
    case ($urandom_range(9))
      0:       ty = -1024;
      1:       ty = 1023;
      2:       ty = ScrH - 1;
      3:       ty = int'($urandom_range(ScrH - 1, ScrH - 10));
      4:       ty = -int'($urandom_range(5, 1));
      default: ty = int'($urandom_range(ScrH - 20));
    endcase
    case ($urandom_range(19))
      0:       w = 0;
      1:       w = 1023;
      default: w = int'($urandom_range(24, 1));
    endcase
    case ($urandom_range(19))
      0:       h = 0;
      1:       h = 1023;
      default: h = int'($urandom_range(10, 1));
    endcase
    set_window(lx, ty, w, h);
    write_reg(CfgDrawMode, 11'($urandom_range(7)));
    write_reg(CfgBrightness, 11'(int'($urandom_range(63)) - 32));
    write_reg(CfgTargetHue, 11'($urandom_range(7)));
    write_reg(CfgMatchHue, 11'($urandom_range(7)));
  endtask

  // Mostly well-formed sprites with random content; some pure noise
  task automatic test_random_sprites();
    int target;
    int rows;
    target = live_bytes + RandomBytes;
    while (live_bytes < target) begin
      wait_idle();
      randomize_regs();
      start_next = 1'b1;
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(30, 10)) begin
          start_next = ($urandom_range(9) == 0);
          put(8'($urandom_range(255)));
        end
      end else begin
        rows = (r_width > 10'd64) ? 2 : 12;
        if (int'(r_height) < rows && r_height != '0) rows = int'(r_height);
        draw_rows(rows, 1'b1);
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_bytes();
    test_modes();
    test_tags();
    test_rejected_starts();
    test_backpressure();
    test_no_gaps();
    test_random_sprites();

    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rsb_pkg.sv
rtl/rsb_shade.sv
rtl/rle_sprite_blitter_core.sv
tb/tb_rle_sprite_blitter_core.sv
